// File: design/record_sort_by_key_assert.svh
// assertion macros used by the checker module
`ifndef RECORD_SORT_BY_KEY_ASSERT_SVH
`define RECORD_SORT_BY_KEY_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RSK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define RSK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/rsk_pkg.sv
`default_nettype none
package rsk_pkg;

	// default store depth
	localparam int MAX_RECORDS_DEF = 8;

	// field widths
	localparam int ID_W   = 8;
	localparam int TIME_W = 16;
	localparam int PRIO_W = 8;
	localparam int KEY_W  = 2;

	// apb port geometry
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = ADDR_W - 2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_SORT_KEY = 1'b0;

	// sort key codes, anything else means no sort
	localparam logic [KEY_W-1:0] KEY_PRIO = 2'd0;
	localparam logic [KEY_W-1:0] KEY_TIME = 2'd1;
	localparam logic [KEY_W-1:0] KEY_NONE = 2'd2;

	// one stored record, id in the top byte, priority in the bottom byte
	typedef struct packed {
		logic [ID_W-1:0]   rid;
		logic [TIME_W-1:0] etime;
		logic [PRIO_W-1:0] prio;
	} rec_t;

endpackage
`default_nettype wire

// File: design/rsk_apb_regs.sv
`default_nettype none
module rsk_apb_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rsk_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [rsk_pkg::DATA_W-1:0]  pwdata,
	output logic      [rsk_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	output logic      [rsk_pkg::KEY_W-1:0]   sort_key
);
	import rsk_pkg::*;

	logic [KEY_W-1:0]     sort_key_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_key_q <= KEY_PRIO;
		end else if (wr_en && reg_idx == REG_SORT_KEY) begin
			sort_key_q <= pwdata[KEY_W-1:0];
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_SORT_KEY: prdata = {{(DATA_W-KEY_W){1'b0}}, sort_key_q};
			default:      prdata = '0;
		endcase
	end

	assign sort_key = sort_key_q;

endmodule
`default_nettype wire

// File: design/record_sort_by_key.sv
// loading: one record per cycle in the load state; after the last beat, the sort
//   runs on the store; emission then sends one record at a time, the next read
//   only after the current beat is taken, all through the record memory with one
//   write and one read port, which every compare and move passes through
// reset: control state, count and key clear at once; the record memory is not cleared
`default_nettype none
module record_sort_by_key #(
	parameter int MAX_RECORDS = rsk_pkg::MAX_RECORDS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rsk_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [rsk_pkg::DATA_W-1:0]  pwdata,
	output logic      [rsk_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [rsk_pkg::ID_W-1:0]    rec_id,
	input  wire logic [rsk_pkg::TIME_W-1:0]  exec_time,
	input  wire logic [rsk_pkg::PRIO_W-1:0]  prio,
	input  wire logic                        last_record,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [rsk_pkg::ID_W-1:0]    out_id,
	output logic      [rsk_pkg::TIME_W-1:0]  out_time,
	output logic      [rsk_pkg::PRIO_W-1:0]  out_prio,
	output logic                             out_last
);
	import rsk_pkg::*;

	localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int CNT_W = $clog2(MAX_RECORDS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);

	typedef enum logic [10:0] {
		ST_LOAD      = 11'b000_0000_0001,
		ST_SEL_START = 11'b000_0000_0010,
		ST_SEL_LDI   = 11'b000_0000_0100,
		ST_SEL_SCAN  = 11'b000_0000_1000,
		ST_SEL_SWAP  = 11'b000_0001_0000,
		ST_SEL_SWAP2 = 11'b000_0010_0000,
		ST_INS_START = 11'b000_0100_0000,
		ST_INS_LDI   = 11'b000_1000_0000,
		ST_INS_CMP   = 11'b001_0000_0000,
		ST_INS_PUT   = 11'b010_0000_0000,
		ST_EMIT_RD   = 11'b100_0000_0000
	} state_t;

	// emission splits into read, capture and wait; capture and wait are sub-phases
	logic emit_cap_q;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [IDX_W-1:0] best_q;
	logic             out_valid_q;
	rec_t             held_q;
	rec_t             best_rec_q;
	rec_t             out_rec_q;
	logic             out_last_q;

	logic [KEY_W-1:0] sort_key;

	// record memory
	rec_t             mem [MAX_RECORDS];
	rec_t             rdata_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	rec_t             mem_wdata;
	logic [IDX_W-1:0] mem_raddr;

	logic             in_fire;
	logic             out_fire;
	logic [CNT_W-1:0] i_inc;
	logic [CNT_W-1:0] i_dec;
	logic [CNT_W-1:0] j_inc;
	logic [CNT_W-1:0] j_dec;
	logic [CNT_W-1:0] j_dec2;
	logic             sel_less;
	logic             ins_greater;
	logic             has_room;

	rsk_apb_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.sort_key (sort_key)
	);

	assign in_ready    = (state_q == ST_LOAD);
	assign in_fire     = in_valid && in_ready;
	assign out_fire    = out_valid_q && out_ready;
	assign i_inc       = i_q + 1'b1;
	assign i_dec       = i_q - 1'b1;
	assign j_inc       = j_q + 1'b1;
	assign j_dec       = j_q - 1'b1;
	assign j_dec2      = j_q - CNT_W'(2);
	assign has_room    = (count_q < CNT_MAX);
	assign sel_less    = (rdata_q.prio < best_rec_q.prio);
	assign ins_greater = (rdata_q.etime > held_q.etime);

	// memory port control per sequencer step
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = i_q[IDX_W-1:0];
		mem_wdata = held_q;
		mem_raddr = i_q[IDX_W-1:0];
		unique case (state_q)
			ST_LOAD: begin
				mem_we    = in_fire && has_room;
				mem_waddr = count_q[IDX_W-1:0];
				mem_wdata = '{rid: rec_id, etime: exec_time, prio: prio};
			end
			ST_SEL_START: mem_raddr = i_q[IDX_W-1:0];
			ST_SEL_LDI:   mem_raddr = i_inc[IDX_W-1:0];
			ST_SEL_SCAN:  mem_raddr = j_inc[IDX_W-1:0];
			ST_SEL_SWAP: begin
				mem_we    = (best_q != i_q[IDX_W-1:0]);
				mem_waddr = i_q[IDX_W-1:0];
				mem_wdata = best_rec_q;
			end
			ST_SEL_SWAP2: begin
				mem_we    = 1'b1;
				mem_waddr = best_q;
				mem_wdata = held_q;
			end
			ST_INS_START: mem_raddr = i_q[IDX_W-1:0];
			ST_INS_LDI:   mem_raddr = i_dec[IDX_W-1:0];
			ST_INS_CMP: begin
				mem_raddr = j_dec2[IDX_W-1:0];
				mem_we    = 1'b1;
				mem_waddr = j_q[IDX_W-1:0];
				mem_wdata = ins_greater ? rdata_q : held_q;
			end
			ST_INS_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = j_q[IDX_W-1:0];
				mem_wdata = held_q;
			end
			ST_EMIT_RD:   mem_raddr = i_q[IDX_W-1:0];
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// memory with one write port and one read port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			best_q      <= '0;
			out_valid_q <= 1'b0;
			emit_cap_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (has_room) begin
							count_q <= count_q + 1'b1;
						end
						if (last_record) begin
							priority if (sort_key == KEY_PRIO) begin
								i_q     <= '0;
								state_q <= ST_SEL_START;
							end else if (sort_key == KEY_TIME) begin
								i_q     <= CNT_W'(1);
								state_q <= ST_INS_START;
							end else begin
								i_q     <= '0;
								state_q <= ST_EMIT_RD;
							end
						end
					end
				end
				ST_SEL_START: begin
					if (i_inc >= count_q) begin
						i_q     <= '0;
						state_q <= ST_EMIT_RD;
					end else begin
						state_q <= ST_SEL_LDI;
					end
				end
				ST_SEL_LDI: begin
					j_q     <= i_inc;
					best_q  <= i_q[IDX_W-1:0];
					state_q <= ST_SEL_SCAN;
				end
				ST_SEL_SCAN: begin
					if (sel_less) begin
						best_q <= j_q[IDX_W-1:0];
					end
					if (j_inc < count_q) begin
						j_q <= j_inc;
					end else begin
						state_q <= ST_SEL_SWAP;
					end
				end
				ST_SEL_SWAP: begin
					if (best_q != i_q[IDX_W-1:0]) begin
						state_q <= ST_SEL_SWAP2;
					end else begin
						i_q     <= i_inc;
						state_q <= ST_SEL_START;
					end
				end
				ST_SEL_SWAP2: begin
					i_q     <= i_inc;
					state_q <= ST_SEL_START;
				end
				ST_INS_START: begin
					if (i_q >= count_q) begin
						i_q     <= '0;
						state_q <= ST_EMIT_RD;
					end else begin
						state_q <= ST_INS_LDI;
					end
				end
				ST_INS_LDI: begin
					j_q     <= i_q;
					state_q <= ST_INS_CMP;
				end
				ST_INS_CMP: begin
					if (ins_greater) begin
						j_q <= j_dec;
						if (j_dec == '0) begin
							state_q <= ST_INS_PUT;
						end
					end else begin
						i_q     <= i_inc;
						state_q <= ST_INS_START;
					end
				end
				ST_INS_PUT: begin
					i_q     <= i_inc;
					state_q <= ST_INS_START;
				end
				ST_EMIT_RD: begin
					// read issued on entry, then capture, then hold until taken
					if (!emit_cap_q && !out_valid_q) begin
						emit_cap_q <= 1'b1;
					end else if (emit_cap_q) begin
						emit_cap_q  <= 1'b0;
						out_valid_q <= 1'b1;
					end else if (out_fire) begin
						out_valid_q <= 1'b0;
						if (i_inc == count_q) begin
							count_q <= '0;
							i_q     <= '0;
							state_q <= ST_LOAD;
						end else begin
							i_q <= i_inc;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// record holding registers
	always_ff @(posedge clk) begin
		if (state_q == ST_SEL_LDI) begin
			held_q     <= rdata_q;
			best_rec_q <= rdata_q;
		end
		if (state_q == ST_SEL_SCAN && sel_less) begin
			best_rec_q <= rdata_q;
		end
		if (state_q == ST_INS_LDI) begin
			held_q <= rdata_q;
		end
		if (state_q == ST_EMIT_RD && emit_cap_q) begin
			out_rec_q  <= rdata_q;
			out_last_q <= (i_inc == count_q);
		end
	end

	// output beat
	assign out_valid = out_valid_q;
	assign out_id    = out_rec_q.rid;
	assign out_time  = out_rec_q.etime;
	assign out_prio  = out_rec_q.prio;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire

// File: design/rsk_checker.sv
`default_nettype none
`include "record_sort_by_key_assert.svh"
module rsk_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        last_record,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [rsk_pkg::ID_W-1:0]    out_id,
	input wire logic [rsk_pkg::TIME_W-1:0]  out_time,
	input wire logic [rsk_pkg::PRIO_W-1:0]  out_prio,
	input wire logic                        out_last
);

	// a stalled output beat keeps its payload
	`RSK_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_id) && $stable(out_time) && $stable(out_prio) && $stable(out_last), "stalled output beat changed")

	// no load while the sorted run drains
	`RSK_ASSERT_NOW(a_no_overlap, clk, arst_n, out_valid, !in_ready, "input taken during emission")

	// the final record ends the run
	`RSK_ASSERT_NEXT(a_run_end, clk, arst_n, out_valid && out_ready && out_last, !out_valid, "beat after final record")

	// last record closes the load phase
	`RSK_ASSERT_NEXT(a_load_end, clk, arst_n, in_valid && in_ready && last_record, !in_ready, "input taken right after last record")

endmodule

bind record_sort_by_key rsk_checker u_rsk_checker (.*);
`default_nettype wire

// File: tb/sv/record_sort_by_key_tb.sv
`default_nettype none
module record_sort_by_key_tb;
	import rsk_pkg::*;

	localparam int NREC = MAX_RECORDS_DEF;
	// reserved key code, behaves like no sort
	localparam logic [KEY_W-1:0] KEY_RSVD = 2'd3;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 20;

	// one record beat with its last flag
	typedef struct packed {
		rec_t r;
		logic last;
	} rec_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	logic in_valid = 1'b0;
	logic in_ready;
	logic [ID_W-1:0] rec_id = '0;
	logic [TIME_W-1:0] exec_time = '0;
	logic [PRIO_W-1:0] prio = '0;
	logic last_record = 1'b0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic [ID_W-1:0] out_id;
	logic [TIME_W-1:0] out_time;
	logic [PRIO_W-1:0] out_prio;
	logic out_last;

	record_sort_by_key #(.MAX_RECORDS(NREC)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.rec_id(rec_id), .exec_time(exec_time), .prio(prio), .last_record(last_record),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_id(out_id), .out_time(out_time), .out_prio(out_prio), .out_last(out_last)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// pending input records and predicted sorted output
	rec_beat_t pending_recs[$];
	rec_beat_t sorted_recs[$];

	// shadow copy of the record store and the key register
	rec_t model_store[NREC];
	int model_count = 0;
	logic [KEY_W-1:0] model_key = KEY_PRIO;

	int err_cnt = 0;
	int idle_cnt = 0;

	// records queued and records accepted so far
	int pushed_cnt = 0;
	int accepted_cnt = 0;

	// swap-based selection sort on priority, first minimum wins
	task automatic sort_by_priority(input int n);
		int i, j, best;
		rec_t t;
		for (i = 0; i + 1 < n; i++) begin
			best = i;
			for (j = i + 1; j < n; j++)
				if (model_store[j].prio < model_store[best].prio)
					best = j;
			if (best != i) begin
				t = model_store[i];
				model_store[i] = model_store[best];
				model_store[best] = t;
			end
		end
	endtask

	// stable insertion sort on execution time
	task automatic sort_by_exec_time(input int n);
		int i, j;
		rec_t held;
		for (i = 1; i < n; i++) begin
			held = model_store[i];
			j = i;
			while (j > 0 && model_store[j-1].etime > held.etime) begin
				model_store[j] = model_store[j-1];
				j--;
			end
			model_store[j] = held;
		end
	endtask

	// store one accepted record; on last, sort and queue the emitted run
	task automatic load_record(input rec_beat_t b);
		int k, n;
		rec_beat_t o;
		if (model_count < NREC) begin
			model_store[model_count] = b.r;
			model_count++;
		end
		if (b.last) begin
			n = model_count;
			if (model_key == KEY_PRIO)
				sort_by_priority(n);
			else if (model_key == KEY_TIME)
				sort_by_exec_time(n);
			for (k = 0; k < n; k++) begin
				o.r = model_store[k];
				o.last = (k + 1 == n);
				sorted_recs.push_back(o);
			end
			model_count = 0;
		end
	endtask

	task automatic push_rec(input int id, input int t, input int p, input bit l);
		rec_beat_t b;
		b.r.rid = ID_W'(id);
		b.r.etime = TIME_W'(t);
		b.r.prio = PRIO_W'(p);
		b.last = l;
		pending_recs.push_back(b);
		pushed_cnt++;
	endtask

	// two-phase register write, key shadow follows at the access edge
	task automatic write_sort_key(input logic [KEY_W-1:0] key);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_SORT_KEY, 2'b00};
		pwdata <= DATA_W'(key);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		model_key = key;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// wait until every record went in and every result came out
	task automatic drain;
		while (accepted_cnt != pushed_cnt || sorted_recs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random sets until about nitems records are queued
	task automatic random_sets(input int nitems);
		int queued, sz, k, pr, tm;
		bit narrow;
		queued = 0;
		while (queued < nitems) begin
			if ($urandom_range(0, 7) == 0)
				sz = $urandom_range(NREC + 1, NREC + 3);
			else
				sz = $urandom_range(1, NREC);
			narrow = 1'($urandom_range(0, 1));
			for (k = 0; k < sz; k++) begin
				pr = narrow ? $urandom_range(0, 3) : $urandom_range(0, 255);
				tm = narrow ? $urandom_range(0, 3) : $urandom_range(0, 65535);
				push_rec($urandom_range(0, 255), tm, pr, k == sz - 1);
			end
			queued += sz;
		end
	endtask

	// input driver: bursts with random gaps between them
	int burst_left = 1;
	int gap_left = 0;
	rec_beat_t drv_beat;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				drv_beat.r.rid = rec_id;
				drv_beat.r.etime = exec_time;
				drv_beat.r.prio = prio;
				drv_beat.last = last_record;
				load_record(drv_beat);
				accepted_cnt++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_recs.size() != 0) begin
					drv_beat = pending_recs.pop_front();
					in_valid <= 1'b1;
					rec_id <= drv_beat.r.rid;
					exec_time <= drv_beat.r.etime;
					prio <= drv_beat.r.prio;
					last_record <= drv_beat.last;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output ready: changing stall modes plus two long hold-offs
	int rx_cycle = 0;
	int rx_beats = 0;
	int hold_left = 0;
	int rx_mode = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (rx_cycle % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			if (out_valid && out_ready) begin
				rx_beats++;
				if (rx_beats == 40 || rx_beats == 250)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (rx_cycle % 4 == 0);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// output monitor: compare each beat with the oldest prediction
	rec_beat_t exp_beat;
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (sorted_recs.size() == 0) begin
				$display("%0t: unexpected output beat id %0d time %0d prio %0d last %0d",
					$time, out_id, out_time, out_prio, out_last);
				err_cnt++;
			end else begin
				exp_beat = sorted_recs.pop_front();
				if (out_id !== exp_beat.r.rid) begin
					$display("%0t: out_id expected %0d actual %0d",
						$time, exp_beat.r.rid, out_id);
					err_cnt++;
				end
				if (out_time !== exp_beat.r.etime) begin
					$display("%0t: out_time expected %0d actual %0d",
						$time, exp_beat.r.etime, out_time);
					err_cnt++;
				end
				if (out_prio !== exp_beat.r.prio) begin
					$display("%0t: out_prio expected %0d actual %0d",
						$time, exp_beat.r.prio, out_prio);
					err_cnt++;
				end
				if (out_last !== exp_beat.last) begin
					$display("%0t: out_last expected %0d actual %0d",
						$time, exp_beat.last, out_last);
					err_cnt++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cnt = 0;
			else
				idle_cnt++;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// stimulus
	logic [KEY_W-1:0] phase_keys[8] = '{KEY_TIME, KEY_NONE, KEY_RSVD, KEY_PRIO,
		KEY_TIME, KEY_PRIO, KEY_NONE, KEY_TIME};
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// priority sort: single extreme record, then ties and overflow
		write_sort_key(KEY_PRIO);
		push_rec(255, 65535, 255, 1);
		push_rec(0, 10, 5, 0);
		push_rec(1, 20, 3, 0);
		push_rec(2, 30, 5, 0);
		push_rec(3, 40, 0, 0);
		push_rec(4, 50, 3, 0);
		push_rec(5, 60, 255, 0);
		push_rec(6, 70, 0, 0);
		push_rec(7, 80, 5, 0);
		// store full: next one dropped, last one dropped but starts emission
		push_rec(8, 90, 0, 0);
		push_rec(9, 0, 0, 1);
		drain();

		// time sort with ties at zero and at 100, plus the maximum time
		write_sort_key(KEY_TIME);
		push_rec(10, 0, 1, 0);
		push_rec(11, 65535, 2, 0);
		push_rec(12, 100, 3, 0);
		push_rec(13, 0, 4, 0);
		push_rec(14, 100, 5, 1);
		drain();

		// no sort
		write_sort_key(KEY_NONE);
		push_rec(0, 0, 0, 0);
		push_rec(255, 65535, 255, 0);
		push_rec(170, 21845, 85, 1);
		drain();

		// reserved key passes through
		write_sort_key(KEY_RSVD);
		push_rec(85, 43690, 170, 0);
		push_rec(1, 2, 0, 0);
		push_rec(2, 1, 255, 1);
		drain();

		foreach (phase_keys[i]) begin
			write_sort_key(phase_keys[i]);
			random_sets(46);
			drain();
		end

		repeat (50) @(posedge clk);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
